// File: rtl/grid_line_of_sight_and_collision_defines.svh
// assertion macros for the grid line-of-sight and collision block
`ifndef GRID_LINE_OF_SIGHT_AND_COLLISION_DEFINES_SVH
`define GRID_LINE_OF_SIGHT_AND_COLLISION_DEFINES_SVH

// same-cycle implication, disabled during reset
`define GLSC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("glsc assertion failed");

// next-cycle implication, disabled during reset
`define GLSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("glsc assertion failed");

`endif

// File: rtl/glsc_pkg.sv
// shared types and constants of the grid line-of-sight and collision block
`timescale 1ns / 1ps

package glsc_pkg;

    localparam int GRID_W_DEF    = 64;
    localparam int GRID_H_DEF    = 64;
    localparam int MAX_STEPS_DEF = 512;

    localparam logic [15:0] CELL_SIZE_RST = 16'd512;

    // iterative divider widths: dividend covers len*5, divisor covers 2*cell
    localparam int DIV_NW = 29;
    localparam int DIV_DW = 17;
    // squared length and probe point widths
    localparam int LEN2_W = 50;
    localparam int PT_W   = 26;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_BLOCK = 2'd1,
        CMD_SIGHT = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_WRITE,
        OP_BLOCK,
        OP_SIGHT
    } t_op;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_BPOINT,
        ST_SQUARE,
        ST_SQRT,
        ST_SDIV,
        ST_SWAIT,
        ST_DDIV,
        ST_DWAIT,
        ST_WALK,
        ST_PSTART,
        ST_PWAIT,
        ST_PCHECK,
        ST_DONE
    } t_bstate;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [5:0]         cell_col;
        logic [5:0]         cell_row;
        logic               cell_value;
        logic signed [23:0] pos_x;
        logic signed [23:0] pos_y;
        logic signed [23:0] pos_z;
        logic signed [23:0] end_x;
        logic signed [23:0] end_y;
        logic signed [23:0] end_z;
        logic [15:0]        radius;
    } t_in;

    typedef struct packed {
        logic answer;
        logic steps_saturated;
    } t_out;

    typedef struct packed {
        t_op                op;
        logic [5:0]         col;
        logic [5:0]         row;
        logic               val;
        logic               wr_ok;
        logic signed [23:0] ax;
        logic signed [23:0] az;
        logic [15:0]        radius;
        logic [23:0]        dxm;
        logic [23:0]        dym;
        logic [23:0]        dzm;
        logic               dxn;
        logic               dzn;
        logic               zero_len;
    } t_job;

endpackage

// File: rtl/glsc_ram.sv
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps

module glsc_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/glsc_div.sv
// restoring unsigned divider, one quotient bit per cycle
`timescale 1ns / 1ps

module glsc_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [glsc_pkg::DIV_NW-1:0]   i_dividend,
    input  logic [glsc_pkg::DIV_DW-1:0]   i_divisor,
    output logic                          o_done,
    output logic [glsc_pkg::DIV_NW-1:0]   o_quot,
    output logic [glsc_pkg::DIV_DW-1:0]   o_rem
);

    localparam int NW = glsc_pkg::DIV_NW;
    localparam int DW = glsc_pkg::DIV_DW;
    localparam int CW = $clog2(NW);

    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [NW-1:0] r_quot, n_quot;
    logic [DW-1:0] r_rem, n_rem;
    logic [DW-1:0] r_dvs, n_dvs;
    logic [DW+1:0] trial;

    always_comb begin
        trial  = {1'b0, r_rem, r_quot[NW-1]} - {2'b00, r_dvs};
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_quot = r_quot;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_quot = i_dividend;
            n_rem  = '0;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            if (!trial[DW+1]) begin
                n_rem  = trial[DW-1:0];
                n_quot = {r_quot[NW-2:0], 1'b1};
            end else begin
                n_rem  = {r_rem[DW-2:0], r_quot[NW-1]};
                n_quot = {r_quot[NW-2:0], 1'b0};
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CW'(NW - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt  <= n_cnt;
        r_quot <= n_quot;
        r_rem  <= n_rem;
        r_dvs  <= n_dvs;
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;

endmodule

// File: rtl/glsc_queue.sv
// short job queue between the front and the back
`timescale 1ns / 1ps

module glsc_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push_valid,
    output logic              o_push_ready,
    input  glsc_pkg::t_job    i_push_job,
    output logic              o_pop_valid,
    input  logic              i_pop_ready,
    output glsc_pkg::t_job    o_pop_job
);

    localparam int D  = glsc_pkg::QUEUE_DEPTH;
    localparam int PW = $clog2(D);

    glsc_pkg::t_job r_mem [D];
    logic [PW-1:0]  r_wp, r_rp;
    logic [PW:0]    r_cnt;
    logic           push, pop;

    assign o_push_ready = (r_cnt != (PW + 1)'(D));
    assign o_pop_valid  = (r_cnt != '0);
    assign o_pop_job    = r_mem[r_rp];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= (r_wp == PW'(D - 1)) ? '0 : r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= (r_rp == PW'(D - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (PW + 1)'(push) - (PW + 1)'(pop);
        end
        if (push) begin
            r_mem[r_wp] <= i_push_job;
        end
    end

endmodule

// File: rtl/glsc_front.sv
// input stage: accepts items, decodes the command and prepares deltas
`timescale 1ns / 1ps

module glsc_front #(
    parameter int GRID_W = glsc_pkg::GRID_W_DEF,
    parameter int GRID_H = glsc_pkg::GRID_H_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  glsc_pkg::t_in    i_data,
    input  logic             i_clearing,
    output logic             o_job_valid,
    input  logic             i_job_ready,
    output glsc_pkg::t_job   o_job
);

    logic           r_valid;
    glsc_pkg::t_job r_job, n_job;
    logic signed [24:0] dx, dy, dz;
    logic [24:0]        ax_abs, ay_abs, az_abs;

    always_comb begin
        dx = {i_data.end_x[23], i_data.end_x} - {i_data.pos_x[23], i_data.pos_x};
        dy = {i_data.end_y[23], i_data.end_y} - {i_data.pos_y[23], i_data.pos_y};
        dz = {i_data.end_z[23], i_data.end_z} - {i_data.pos_z[23], i_data.pos_z};
        ax_abs = dx[24] ? 25'(-dx) : 25'(dx);
        ay_abs = dy[24] ? 25'(-dy) : 25'(dy);
        az_abs = dz[24] ? 25'(-dz) : 25'(dz);

        n_job.col      = i_data.cell_col;
        n_job.row      = i_data.cell_row;
        n_job.val      = i_data.cell_value;
        n_job.wr_ok    = ({26'd0, i_data.cell_col} < 32'(GRID_W)) &&
                         ({26'd0, i_data.cell_row} < 32'(GRID_H));
        n_job.ax       = i_data.pos_x;
        n_job.az       = i_data.pos_z;
        n_job.radius   = i_data.radius;
        n_job.dxm      = ax_abs[23:0];
        n_job.dym      = ay_abs[23:0];
        n_job.dzm      = az_abs[23:0];
        n_job.dxn      = dx[24];
        n_job.dzn      = dz[24];
        n_job.zero_len = (dx == '0) && (dy == '0) && (dz == '0);
        unique case (i_data.cmd)
            glsc_pkg::CMD_WRITE: n_job.op = glsc_pkg::OP_WRITE;
            glsc_pkg::CMD_BLOCK: n_job.op = glsc_pkg::OP_BLOCK;
            glsc_pkg::CMD_SIGHT: n_job.op = glsc_pkg::OP_SIGHT;
            default:             n_job.op = glsc_pkg::OP_NONE;
        endcase
    end

    // hold off while the grid is being cleared
    assign o_ready     = (!r_valid || i_job_ready) && !i_clearing;
    assign o_job_valid = r_valid;
    assign o_job       = r_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end else if (i_job_ready) begin
            r_valid <= 1'b0;
        end
        if (o_ready && i_valid) begin
            r_job <= n_job;
        end
    end

endmodule

// File: rtl/glsc_back.sv
// execution stage: grid memory, probes, length, step count and line walk
`timescale 1ns / 1ps

module glsc_back #(
    parameter int GRID_W    = glsc_pkg::GRID_W_DEF,
    parameter int GRID_H    = glsc_pkg::GRID_H_DEF,
    parameter int MAX_STEPS = glsc_pkg::MAX_STEPS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [15:0]      i_cell_size,
    input  logic             i_job_valid,
    output logic             o_job_ready,
    input  glsc_pkg::t_job   i_job,
    output logic             o_clearing,
    output logic             o_valid,
    input  logic             i_ready,
    output glsc_pkg::t_out   o_data
);

    localparam int CELLS = GRID_W * GRID_H;
    localparam int AW    = $clog2(CELLS);
    localparam int SW    = $clog2(MAX_STEPS + 1);
    localparam int NW    = glsc_pkg::DIV_NW;
    localparam int DW    = glsc_pkg::DIV_DW;
    localparam int PW    = glsc_pkg::PT_W;
    localparam int LW    = glsc_pkg::LEN2_W;

    glsc_pkg::t_bstate r_state, n_state;
    glsc_pkg::t_job    r_job, n_job;
    glsc_pkg::t_out    r_odata, n_odata;
    logic              r_ovalid, n_ovalid;
    logic [AW-1:0]     r_clr, n_clr;
    logic [1:0]        r_corner, n_corner;
    logic [1:0]        r_mcnt, n_mcnt;
    logic signed [PW-1:0] r_px, n_px, r_pz, n_pz;
    logic signed [PW-1:0] r_qx, n_qx, r_qz, n_qz;
    logic signed [PW-1:0] r_dqx, n_dqx, r_dqz, n_dqz;
    logic [SW-1:0]     r_rx, n_rx, r_rz, n_rz;
    logic [SW-1:0]     r_drx, n_drx, r_drz, n_drz;
    logic [SW-1:0]     r_steps, n_steps, r_i, n_i;
    logic [47:0]       r_prod, n_prod;
    logic [LW-1:0]     r_acc, n_acc, r_v, n_v, r_res, n_res, r_bit, n_bit;
    logic              r_ans, n_ans, r_sat, n_sat;

    // memory and divider hookups
    logic          we, wdata, rdata;
    logic [AW-1:0] waddr, raddr;
    logic          div_start_x, div_start_z, done_x, done_z;
    logic [NW-1:0] dvd_x, dvd_z, qx_d, qz_d;
    logic [DW-1:0] dvs, rx_d, rz_d;

    // shared combinational terms
    logic [DW-1:0]        cdiv;
    logic                 p_neg, oob, probe_end, probe_solid;
    logic [23:0]          mag;
    logic [47:0]          sq;
    logic [LW-1:0]        root_try;
    logic [24:0]          len;
    logic [NW:0]          qs;
    logic signed [PW-1:0] ax_ext, az_ext, rad, q0x, q0z;
    logic [SW-1:0]        r0x, r0z, i1;
    logic [SW:0]          sumx, sumz;
    logic                 wrapx, wrapz;
    logic signed [PW-1:0] wqx, wqz;

    glsc_ram #(.WIDTH(1), .DEPTH(CELLS)) u_grid (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    glsc_div u_div_x (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start_x),
        .i_dividend (dvd_x),
        .i_divisor  (dvs),
        .o_done     (done_x),
        .o_quot     (qx_d),
        .o_rem      (rx_d)
    );

    glsc_div u_div_z (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start_z),
        .i_dividend (dvd_z),
        .i_divisor  (dvs),
        .o_done     (done_z),
        .o_quot     (qz_d),
        .o_rem      (rz_d)
    );

    always_comb begin
        cdiv   = (i_cell_size == '0) ? DW'(1) : {1'b0, i_cell_size};
        ax_ext = PW'(r_job.ax);
        az_ext = PW'(r_job.az);
        rad    = PW'({1'b0, r_job.radius});
        p_neg  = r_px[PW-1] || r_pz[PW-1];
        oob    = (qx_d >= NW'(GRID_W)) || (qz_d >= NW'(GRID_H));
        raddr  = AW'(qz_d) * AW'(GRID_W) + AW'(qx_d);
        case (r_mcnt)
            2'd0:    mag = r_job.dxm;
            2'd1:    mag = r_job.dym;
            default: mag = r_job.dzm;
        endcase
        sq       = mag * mag;
        root_try = r_res + r_bit;
        len      = r_res[24:0];
        qs       = {1'b0, qx_d} + (NW + 1)'(1);
        q0x      = PW'(qx_d);
        q0z      = PW'(qz_d);
        r0x      = SW'(rx_d);
        r0z      = SW'(rz_d);
        i1       = r_i + 1'b1;
        sumx     = {1'b0, r_rx} + {1'b0, r_drx};
        sumz     = {1'b0, r_rz} + {1'b0, r_drz};
        wrapx    = sumx >= {1'b0, r_steps};
        wrapz    = sumz >= {1'b0, r_steps};
        wqx      = r_qx + r_dqx + PW'(wrapx);
        wqz      = r_qz + r_dqz + PW'(wrapz);
    end

    // end of a cell probe and whether the cell was solid
    always_comb begin
        probe_end   = 1'b0;
        probe_solid = 1'b1;
        case (r_state)
            glsc_pkg::ST_PSTART: probe_end = p_neg;
            glsc_pkg::ST_PWAIT:  probe_end = done_x && done_z && oob;
            glsc_pkg::ST_PCHECK: begin
                probe_end   = 1'b1;
                probe_solid = !rdata;
            end
            default: probe_end = 1'b0;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        if (probe_end) begin
            if (r_job.op == glsc_pkg::OP_BLOCK) begin
                n_state = (probe_solid || r_corner == 2'd3) ? glsc_pkg::ST_DONE
                                                             : glsc_pkg::ST_BPOINT;
            end else begin
                n_state = probe_solid ? glsc_pkg::ST_DONE : glsc_pkg::ST_WALK;
            end
        end else begin
            unique case (r_state)
                glsc_pkg::ST_CLEAR: begin
                    if (r_clr == AW'(CELLS - 1)) n_state = glsc_pkg::ST_IDLE;
                end
                glsc_pkg::ST_IDLE: begin
                    if (i_job_valid) begin
                        case (i_job.op)
                            glsc_pkg::OP_BLOCK: n_state = glsc_pkg::ST_BPOINT;
                            glsc_pkg::OP_SIGHT: n_state = i_job.zero_len ? glsc_pkg::ST_DONE
                                                                         : glsc_pkg::ST_SQUARE;
                            default:            n_state = glsc_pkg::ST_DONE;
                        endcase
                    end
                end
                glsc_pkg::ST_BPOINT: n_state = glsc_pkg::ST_PSTART;
                glsc_pkg::ST_SQUARE: begin
                    if (r_mcnt == 2'd3) n_state = glsc_pkg::ST_SQRT;
                end
                glsc_pkg::ST_SQRT: begin
                    if (r_bit == '0) n_state = glsc_pkg::ST_SDIV;
                end
                glsc_pkg::ST_SDIV: n_state = glsc_pkg::ST_SWAIT;
                glsc_pkg::ST_SWAIT: begin
                    if (done_x) n_state = glsc_pkg::ST_DDIV;
                end
                glsc_pkg::ST_DDIV: n_state = glsc_pkg::ST_DWAIT;
                glsc_pkg::ST_DWAIT: begin
                    if (done_x && done_z) n_state = glsc_pkg::ST_WALK;
                end
                glsc_pkg::ST_WALK: begin
                    n_state = (i1 == r_steps) ? glsc_pkg::ST_DONE : glsc_pkg::ST_PSTART;
                end
                glsc_pkg::ST_PSTART: n_state = glsc_pkg::ST_PWAIT;
                glsc_pkg::ST_PWAIT: begin
                    if (done_x && done_z) n_state = glsc_pkg::ST_PCHECK;
                end
                glsc_pkg::ST_PCHECK: n_state = glsc_pkg::ST_DONE;
                glsc_pkg::ST_DONE: begin
                    if (!r_ovalid || i_ready) n_state = glsc_pkg::ST_IDLE;
                end
                default: n_state = glsc_pkg::ST_IDLE;
            endcase
        end
    end

    // datapath and control outputs
    always_comb begin
        n_job = r_job;  n_odata = r_odata;  n_clr = r_clr;
        n_corner = r_corner;  n_mcnt = r_mcnt;
        n_px = r_px;  n_pz = r_pz;  n_qx = r_qx;  n_qz = r_qz;
        n_dqx = r_dqx;  n_dqz = r_dqz;  n_rx = r_rx;  n_rz = r_rz;
        n_drx = r_drx;  n_drz = r_drz;  n_steps = r_steps;  n_i = r_i;
        n_prod = r_prod;  n_acc = r_acc;  n_v = r_v;  n_res = r_res;  n_bit = r_bit;
        n_ans = r_ans;  n_sat = r_sat;
        n_ovalid = r_ovalid && !i_ready;
        we = 1'b0;  waddr = r_clr;  wdata = 1'b0;
        div_start_x = 1'b0;  div_start_z = 1'b0;
        dvd_x = NW'(unsigned'(r_px));  dvd_z = NW'(unsigned'(r_pz));  dvs = cdiv;

        if (probe_end) begin
            if (r_job.op == glsc_pkg::OP_BLOCK) begin
                n_ans    = probe_solid;
                n_corner = r_corner + 1'b1;
            end else begin
                n_ans = !probe_solid;
            end
        end

        case (r_state)
            glsc_pkg::ST_CLEAR: begin
                we    = 1'b1;
                n_clr = r_clr + 1'b1;
            end
            glsc_pkg::ST_IDLE: begin
                if (i_job_valid) begin
                    n_job    = i_job;
                    n_sat    = 1'b0;
                    n_ans    = (i_job.op == glsc_pkg::OP_SIGHT) && i_job.zero_len;
                    n_corner = '0;
                    n_mcnt   = '0;
                    n_acc    = '0;
                    waddr    = AW'(i_job.row) * AW'(GRID_W) + AW'(i_job.col);
                    wdata    = i_job.val;
                    we       = (i_job.op == glsc_pkg::OP_WRITE) && i_job.wr_ok;
                end
            end
            glsc_pkg::ST_BPOINT: begin
                n_px = r_corner[0] ? ax_ext + rad : ax_ext - rad;
                n_pz = r_corner[1] ? az_ext + rad : az_ext - rad;
            end
            glsc_pkg::ST_SQUARE: begin
                n_mcnt = r_mcnt + 1'b1;
                n_prod = sq;
                if (r_mcnt != 2'd0) n_acc = r_acc + LW'(r_prod);
                if (r_mcnt == 2'd3) begin
                    n_v   = r_acc + LW'(r_prod);
                    n_res = '0;
                    n_bit = LW'(1) << (LW - 2);
                end
            end
            glsc_pkg::ST_SQRT: begin
                if (r_bit != '0) begin
                    if (r_v >= root_try) begin
                        n_v   = r_v - root_try;
                        n_res = (r_res >> 1) + r_bit;
                    end else begin
                        n_res = r_res >> 1;
                    end
                    n_bit = r_bit >> 2;
                end
            end
            glsc_pkg::ST_SDIV: begin
                div_start_x = 1'b1;
                dvd_x       = (NW'(len) << 2) + NW'(len);
                dvs         = {cdiv[DW-2:0], 1'b0};
            end
            glsc_pkg::ST_SWAIT: begin
                if (done_x) begin
                    if (qs > (NW + 1)'(MAX_STEPS)) begin
                        n_steps = SW'(MAX_STEPS);
                        n_sat   = 1'b1;
                    end else begin
                        n_steps = SW'(qs);
                    end
                end
            end
            glsc_pkg::ST_DDIV: begin
                div_start_x = 1'b1;
                div_start_z = 1'b1;
                dvd_x       = NW'(r_job.dxm);
                dvd_z       = NW'(r_job.dzm);
                dvs         = DW'(r_steps);
            end
            glsc_pkg::ST_DWAIT: begin
                if (done_x && done_z) begin
                    // floor division of the signed delta by the step count
                    n_dqx = !r_job.dxn ? q0x : ((r0x != '0) ? -q0x - PW'(1) : -q0x);
                    n_dqz = !r_job.dzn ? q0z : ((r0z != '0) ? -q0z - PW'(1) : -q0z);
                    n_drx = (r_job.dxn && r0x != '0) ? r_steps - r0x : r0x;
                    n_drz = (r_job.dzn && r0z != '0) ? r_steps - r0z : r0z;
                    n_i   = '0;
                    n_qx  = '0;
                    n_qz  = '0;
                    n_rx  = '0;
                    n_rz  = '0;
                end
            end
            glsc_pkg::ST_WALK: begin
                if (i1 == r_steps) begin
                    n_ans = 1'b1;
                end else begin
                    n_i  = i1;
                    n_qx = wqx;
                    n_qz = wqz;
                    n_rx = wrapx ? SW'(sumx - {1'b0, r_steps}) : SW'(sumx);
                    n_rz = wrapz ? SW'(sumz - {1'b0, r_steps}) : SW'(sumz);
                    n_px = ax_ext + wqx;
                    n_pz = az_ext + wqz;
                end
            end
            glsc_pkg::ST_PSTART: begin
                div_start_x = !p_neg;
                div_start_z = !p_neg;
            end
            glsc_pkg::ST_DONE: begin
                if (!r_ovalid || i_ready) begin
                    n_ovalid = 1'b1;
                    n_odata  = '{answer: r_ans, steps_saturated: r_sat};
                end
            end
            default: n_clr = r_clr;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= glsc_pkg::ST_CLEAR;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_ovalid <= n_ovalid;
        end
        r_job <= n_job;  r_odata <= n_odata;
        r_corner <= n_corner;  r_mcnt <= n_mcnt;
        r_px <= n_px;  r_pz <= n_pz;  r_qx <= n_qx;  r_qz <= n_qz;
        r_dqx <= n_dqx;  r_dqz <= n_dqz;  r_rx <= n_rx;  r_rz <= n_rz;
        r_drx <= n_drx;  r_drz <= n_drz;  r_steps <= n_steps;  r_i <= n_i;
        r_prod <= n_prod;  r_acc <= n_acc;  r_v <= n_v;  r_res <= n_res;
        r_bit <= n_bit;  r_ans <= n_ans;  r_sat <= n_sat;
    end

    assign o_job_ready = (r_state == glsc_pkg::ST_IDLE);
    assign o_clearing  = (r_state == glsc_pkg::ST_CLEAR);
    assign o_valid     = r_ovalid;
    assign o_data      = r_odata;

endmodule

// File: rtl/grid_line_of_sight_and_collision.sv
// top level of the grid line-of-sight and collision block
`timescale 1ns / 1ps

// channel   | direction | handshake              | payload
// ----------+-----------+------------------------+------------------------
// input     | in        | i_valid / o_ready      | i_data (glsc_pkg::t_in)
// result    | out       | o_valid / i_ready      | o_data (glsc_pkg::t_out)
// config    | in        | i_cfg_valid / o_cfg_ready | i_cfg_data (cell size)
//
// after reset the grid is swept to solid, one cell a cycle, while o_ready
// stays low (config writes are still taken)
// blocked query: up to 4 probes, each a cell division and a grid read
// sight query: squaring, square root and two divider runs, then one cell
// division per sample; up to MAX_STEPS samples
// a two-entry queue sits between decode and execution, and the result
// register lets the next item run while a finished item waits to be taken

module grid_line_of_sight_and_collision #(
    parameter int GRID_W    = glsc_pkg::GRID_W_DEF,
    parameter int GRID_H    = glsc_pkg::GRID_H_DEF,
    parameter int MAX_STEPS = glsc_pkg::MAX_STEPS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  glsc_pkg::t_in   i_data,
    output logic            o_valid,
    input  logic            i_ready,
    output glsc_pkg::t_out  o_data,
    input  logic            i_cfg_valid,
    output logic            o_cfg_ready,
    input  logic [15:0]     i_cfg_data
);

    // cell size register, unsigned, on the same scale as the positions
    logic [15:0] r_cell_size;

    // front to queue
    logic           f_valid, f_ready;
    glsc_pkg::t_job f_job;
    // queue to back
    logic           b_valid, b_ready;
    glsc_pkg::t_job b_job;
    // back is sweeping the grid
    logic           clearing;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell_size <= glsc_pkg::CELL_SIZE_RST;
        end else if (i_cfg_valid) begin
            r_cell_size <= i_cfg_data;
        end
    end

    // decode and delta preparation
    glsc_front #(.GRID_W(GRID_W), .GRID_H(GRID_H)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data      (i_data),
        .i_clearing  (clearing),
        .o_job_valid (f_valid),
        .i_job_ready (f_ready),
        .o_job       (f_job)
    );

    // decouples decode from the long-running execution
    glsc_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (f_valid),
        .o_push_ready (f_ready),
        .i_push_job   (f_job),
        .o_pop_valid  (b_valid),
        .i_pop_ready  (b_ready),
        .o_pop_job    (b_job)
    );

    // grid memory, probes, length root, step division and line walk
    glsc_back #(.GRID_W(GRID_W), .GRID_H(GRID_H), .MAX_STEPS(MAX_STEPS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cell_size (r_cell_size),
        .i_job_valid (b_valid),
        .o_job_ready (b_ready),
        .i_job       (b_job),
        .o_clearing  (clearing),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_data      (o_data)
    );

endmodule

// File: rtl/glsc_chk.sv
// port-level checker for the grid line-of-sight and collision block
`timescale 1ns / 1ps
`include "grid_line_of_sight_and_collision_defines.svh"

module glsc_chk (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           o_ready,
    input logic           o_valid,
    input logic           i_ready,
    input glsc_pkg::t_out o_data
);

    // no result and no intake right after reset
    `GLSC_ASSERT_NOW(a_rst_quiet, i_clk, i_rst_n, $past(!i_rst_n), !o_valid && !o_ready)
    // grid sweep keeps intake closed after reset is released
    `GLSC_ASSERT_NOW(a_sweep_holds, i_clk, i_rst_n, $past(!i_rst_n, 2) && $past(i_rst_n), !o_ready)
    // stalled result holds
    `GLSC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_data))

endmodule

bind grid_line_of_sight_and_collision glsc_chk u_chk (.*);

// File: sim/grid_line_of_sight_and_collision_test.sv
// self-checking testbench of the grid line-of-sight and collision block
`timescale 1ns / 1ps

module grid_line_of_sight_and_collision_test;
    import glsc_pkg::*;

    localparam int          GW         = GRID_W_DEF;
    localparam int          GH         = GRID_H_DEF;
    localparam int          STEP_LIMIT = MAX_STEPS_DEF;
    localparam logic [1:0]  CMD_UNUSED = 2'd3;
    localparam int          LONG_HOLD  = 3000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    t_in         i_data = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    t_out        o_data;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data = '0;

    grid_line_of_sight_and_collision uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_data(i_data),
        .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    // shadow of the block: open map and cell size
    bit          open_map [GW*GH];
    logic [15:0] cell_reg = CELL_SIZE_RST;

    t_in  pending_items [$];
    t_out expected_answers [$];
    int   errors = 0;
    bit   no_gaps = 1'b0;
    bit   hold_kick = 1'b0;
    int   hold_cnt = 0;

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // ---------------- grid predictor ----------------
    function automatic longint floor_quot(longint n, longint d);
        longint q;
        q = n / d;
        if ((n % d) != 0 && n < 0) q = q - 1;
        return q;
    endfunction

    function automatic longint cell_span();
        return (cell_reg == 0) ? 1 : longint'(cell_reg);
    endfunction

    function automatic bit is_solid(longint wx, longint wz);
        longint col, row;
        col = floor_quot(wx, cell_span());
        row = floor_quot(wz, cell_span());
        if (col < 0 || row < 0 || col >= GW || row >= GH) return 1'b1;
        return !open_map[row*GW + col];
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // applies one item to the shadow grid and returns its answer
    function automatic t_out predict_answer(t_in it);
        t_out o;
        longint x, z, r, ax, az, dx, dy, dz, steps, i;
        longint unsigned len;
        o = '0;
        case (it.cmd)
            CMD_WRITE: begin
                // 6-bit indexes always land inside a 64x64 grid
                if (it.cell_col < GW && it.cell_row < GH)
                    open_map[it.cell_row*GW + it.cell_col] = it.cell_value;
            end
            CMD_BLOCK: begin
                x = longint'(it.pos_x);
                z = longint'(it.pos_z);
                r = longint'(it.radius);
                o.answer = is_solid(x-r, z-r) || is_solid(x+r, z-r) ||
                           is_solid(x-r, z+r) || is_solid(x+r, z+r);
            end
            CMD_SIGHT: begin
                ax = longint'(it.pos_x);
                az = longint'(it.pos_z);
                dx = longint'(it.end_x) - ax;
                dy = longint'(it.end_y) - longint'(it.pos_y);
                dz = longint'(it.end_z) - az;
                len = int_sqrt(dx*dx + dy*dy + dz*dz);
                o.answer = 1'b1;
                if (len != 0) begin
                    steps = (len * 5) / (2 * cell_span()) + 1;
                    if (steps > STEP_LIMIT) begin
                        steps = STEP_LIMIT;
                        o.steps_saturated = 1'b1;
                    end
                    for (i = 1; i < steps; i++) begin
                        if (is_solid(ax + floor_quot(dx*i, steps),
                                     az + floor_quot(dz*i, steps))) begin
                            o.answer = 1'b0;
                            break;
                        end
                    end
                end
            end
            default: ;
        endcase
        return o;
    endfunction

    function automatic int draw_wait();
        return no_gaps ? 0 : $urandom_range(0, 9);
    endfunction

    // ---------------- driver ----------------
    int tx_wait = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                // item taken: predict now, in acceptance order
                expected_answers.push_back(predict_answer(i_data));
                tx_wait = draw_wait();
            end else if (!i_valid && tx_wait > 0) begin
                tx_wait--;
            end
            if (!i_valid || o_ready) begin
                if (tx_wait == 0 && pending_items.size() > 0) begin
                    i_data  <= pending_items.pop_front();
                    i_valid <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------- long receiver hold ----------------
    always @(posedge i_clk) begin
        if (hold_kick) hold_cnt <= LONG_HOLD;
        else if (hold_cnt > 0) hold_cnt <= hold_cnt - 1;
    end

    // ---------------- monitor ----------------
    task automatic report(string what, int got, int want);
        errors++;
        $display("mismatch %0s: got %0d want %0d at %0t", what, got, want, $realtime);
    endtask

    int rx_wait = 0;
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (expected_answers.size() == 0) begin
                    report("unexpected result", o_data, 0);
                end else begin
                    want = expected_answers.pop_front();
                    if (o_data.answer !== want.answer)
                        report("answer", o_data.answer, want.answer);
                    if (o_data.steps_saturated !== want.steps_saturated)
                        report("steps_saturated", o_data.steps_saturated,
                               want.steps_saturated);
                end
                rx_wait = draw_wait();
            end else if (rx_wait > 0) begin
                rx_wait--;
            end
            i_ready <= (rx_wait == 0) && (hold_cnt == 0) && !hold_kick;
        end
    end

    // ---------------- stimulus ----------------
    function automatic t_in noise_item();
        t_in it;
        it.cmd        = $urandom_range(0, 3);
        it.cell_col   = $urandom;
        it.cell_row   = $urandom;
        it.cell_value = $urandom;
        it.pos_x      = $urandom;
        it.pos_y      = $urandom;
        it.pos_z      = $urandom;
        it.end_x      = $urandom;
        it.end_y      = $urandom;
        it.end_z      = $urandom;
        it.radius     = $urandom;
        return it;
    endfunction

    function automatic int spread(int k);
        return int'($urandom_range(0, 2*k)) - k;
    endfunction

    // mostly well-formed items aimed at the opened corner of the grid
    function automatic t_in random_item();
        t_in it;
        int c, lim, sel;
        it  = noise_item();
        c   = int'(cell_span());
        lim = ($urandom_range(0, 3) == 0) ? GW*c : 16*c;
        sel = $urandom_range(0, 99);
        if (sel < 30) begin
            it.cmd        = CMD_WRITE;
            it.cell_col   = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 15);
            it.cell_row   = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 15);
            it.cell_value = ($urandom_range(0, 9) < 7);
        end else if (sel < 60) begin
            it.cmd    = CMD_BLOCK;
            it.pos_x  = int'($urandom_range(0, lim + 2*c)) - c;
            it.pos_z  = int'($urandom_range(0, lim + 2*c)) - c;
            it.radius = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, c);
        end else if (sel < 95) begin
            it.cmd   = CMD_SIGHT;
            it.pos_x = $urandom_range(0, lim);
            it.pos_z = $urandom_range(0, lim);
            it.pos_y = spread(4*c);
            it.end_x = it.pos_x + spread(6*c);
            it.end_z = it.pos_z + spread(6*c);
            it.end_y = it.pos_y + spread(2*c);
        end
        return it;
    endfunction

    function automatic t_in sight(int px, int py, int pz, int ex, int ey, int ez);
        t_in it;
        it = '0;
        it.cmd = CMD_SIGHT;
        it.pos_x = px; it.pos_y = py; it.pos_z = pz;
        it.end_x = ex; it.end_y = ey; it.end_z = ez;
        return it;
    endfunction

    function automatic t_in probe(int px, int pz, int r);
        t_in it;
        it = '0;
        it.cmd = CMD_BLOCK;
        it.pos_x = px; it.pos_z = pz; it.radius = r;
        return it;
    endfunction

    function automatic t_in cell_write(int col, int row, bit v);
        t_in it;
        it = '0;
        it.cmd = CMD_WRITE;
        it.cell_col = col; it.cell_row = row; it.cell_value = v;
        return it;
    endfunction

    // sampled away from the active edge so driver and monitor updates have settled
    task automatic wait_drained();
        while (pending_items.size() > 0 || i_valid || expected_answers.size() > 0)
            @(negedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_cell_size(logic [15:0] v);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        cell_reg = v;
    endtask

    task automatic directed_items();
        t_in it;
        pending_items.push_back(cell_write(0, 0, 1'b1));
        pending_items.push_back(cell_write(1, 0, 1'b1));
        pending_items.push_back(cell_write(63, 63, 1'b1));
        pending_items.push_back(cell_write(63, 0, 1'b0));
        pending_items.push_back(cell_write(5, 5, 1'b0));
        // unused command with every field at its top
        it = '1;
        it.cmd = CMD_UNUSED;
        pending_items.push_back(it);
        pending_items.push_back(probe(256, 256, 0));
        pending_items.push_back(probe(256, 256, 65535));
        pending_items.push_back(probe(-8388608, -8388608, 0));
        pending_items.push_back(probe(8388607, 8388607, 65535));
        pending_items.push_back(probe(63*512 + 256, 63*512 + 256, 0));
        pending_items.push_back(probe(512, 256, 0));
        // zero length lines at both ends of the range
        pending_items.push_back(sight(8388607, 8388607, 8388607, 8388607, 8388607, 8388607));
        pending_items.push_back(sight(-8388608, -8388608, -8388608,
                                      -8388608, -8388608, -8388608));
        // step clamp through open cells: height alone makes the line long
        pending_items.push_back(sight(256, -8388608, 256, 768, 8388607, 256));
        // step clamp ending on the first solid sample
        pending_items.push_back(sight(-8388608, 0, 0, 8388607, 0, 0));
        pending_items.push_back(sight(0, 0, -8388608, 0, 0, 8388607));
        pending_items.push_back(sight(256, 0, 256, 700, 0, 256));
        pending_items.push_back(sight(256, 0, 256, 256, 0, 2000));
    endtask

    logic [15:0] phase_sizes [6];

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        phase_sizes = '{16'd512, 16'd1, 16'd65535, 16'd0, 16'd37, 16'd0};
        phase_sizes[5] = $urandom_range(2, 2000);
        for (int ph = 0; ph < 6; ph++) begin
            write_cell_size(phase_sizes[ph]);
            if (ph == 0) directed_items();
            if (ph == 2) begin
                // receiver holds off while items keep coming
                @(posedge i_clk);
                hold_kick <= 1'b1;
                @(posedge i_clk);
                hold_kick <= 1'b0;
            end
            no_gaps = (ph == 1 || ph == 4);
            repeat (135) pending_items.push_back(random_item());
            // sender pauses here until every answer is back
            wait_drained();
            no_gaps = 1'b0;
            repeat (135) pending_items.push_back(random_item());
            wait_drained();
        end
        repeat (200) @(posedge i_clk);
        if (errors == 0)
            $display("grid_line_of_sight_and_collision_test: clean");
        else
            $display("grid_line_of_sight_and_collision_test: errors");
        $finish;
    end

    initial begin
        #400_000_000;
        $display("grid_line_of_sight_and_collision_test: errors");
        $finish;
    end

endmodule
